>>> hdl/dac_pkg.sv
// Shared types and constants for the decimal accumulator machine.
// Depends on nothing; every other file imports it.
package dac_pkg;

  // Decode constants
  localparam logic [31:0] DEC_SPLIT = 32'd10000;
  localparam logic [31:0] READ_MOD  = 32'd1000000;

  // Reciprocals for the constant splits: q = (x * MAGIC) >> SHIFT, exact for 32-bit x
  localparam logic [31:0] DEC_MAGIC  = 32'hD1B7_1759;
  localparam int          DEC_SHIFT  = 45;
  localparam logic [31:0] READ_MAGIC = 32'h431B_DE83;
  localparam int          READ_SHIFT = 50;

  // Opcode field is wide enough for any positive word divided by DEC_SPLIT
  localparam int OP_W = 18;

  localparam logic [OP_W-1:0] OP_ADD  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_SUB  = OP_W'(2);
  localparam logic [OP_W-1:0] OP_MUL  = OP_W'(3);
  localparam logic [OP_W-1:0] OP_DIV  = OP_W'(4);
  localparam logic [OP_W-1:0] OP_LDA  = OP_W'(5);
  localparam logic [OP_W-1:0] OP_STA  = OP_W'(6);
  localparam logic [OP_W-1:0] OP_READ = OP_W'(7);
  localparam logic [OP_W-1:0] OP_DISP = OP_W'(8);
  localparam logic [OP_W-1:0] OP_JMP  = OP_W'(9);
  localparam logic [OP_W-1:0] OP_JNEG = OP_W'(10);
  localparam logic [OP_W-1:0] OP_JZ   = OP_W'(11);
  localparam logic [OP_W-1:0] OP_JPOS = OP_W'(12);
  localparam logic [OP_W-1:0] OP_HALT = OP_W'(13);

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [13:0] load_address;
    logic [31:0] load_value;
    logic [31:0] read_value;
  } req_t;

  typedef struct packed {
    logic        load_ok;
    logic        display_valid;
    logic [31:0] display_value;
    logic        halted;
    logic        divide_fault;
    logic [13:0] next_pc;
  } res_t;

  // Divide selection: word and read splits use the reciprocal unit,
  // the accumulator divide uses the bit-serial divider
  typedef enum logic [1:0] {
    DIV_WORD = 2'd0,
    DIV_ACC  = 2'd1,
    DIV_READ = 2'd2
  } div_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     latch;
    logic     load_wr;
    logic     fin_state;
    logic     set_halt;
    logic     rd_pc;
    logic     rd_opnd;
    logic     clr_op;
    logic     cap_dec;
    logic     div_start;
    div_sel_e div_sel;
    logic     exec;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_type;
    logic halted;
    logic pc_oob;
    logic word_nop;
    logic div_busy;
    logic need_div;
    logic need_read;
  } stat_t;

endpackage

>>> hdl/decimal_accumulator_cpu_step_top.sv
// Decimal accumulator machine: one load or one instruction step per item.
// Depends on dac_pkg, dac_ctrl, dac_datapath (which holds dac_div).
//
// Request channel: an item (req_i) is taken on a rising edge with start high
// and busy low. Result channel: done_o is high for exactly one cycle with the
// result on res_o; the receiver cannot stall, so nothing is held back.
// busy drops in the cycle the result is shown, so the next item can be
// taken while that result is on the ports.
// Sequence after acceptance: a load item, or a step while halted or past
// the end of memory, finishes straight from dispatch. Other steps fetch the
// word, split a positive word into opcode and address by reciprocal
// multiply (a zero or negative word skips the split), read the operand and
// execute; a read instruction adds a second reciprocal pass for the
// remainder, a divide instruction the 32-step bit-serial divider.
// One item at a time: a new item is taken only once the controller sequence
// and, for divides, the divider have finished.
// Reset clears accumulator, program counter and both flags; the word memory
// has no reset and holds garbage until loaded.
module decimal_accumulator_cpu_step_top
  import dac_pkg::*;
#(
  parameter int MEM_WORDS = 10000
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  cmd_t  cmd;
  stat_t stat;

  dac_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  dac_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

>>> hdl/dac_div.sv
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// Depends on dac_pkg only by house convention (no items from it are used).
module dac_div
  import dac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic [32:0] trial;

  // One shift-subtract step per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    trial  = {rem_q[31:0], quot_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = trial - {1'b0, dsr_q};
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

>>> hdl/dac_datapath.sv
// Datapath: word memory, accumulator, program counter, flags, divider, result register.
// Depends on dac_pkg and dac_div.
module dac_datapath
  import dac_pkg::*;
#(
  parameter int MEM_WORDS = 10000
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output logic  done_o,
  output res_t  res_o
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [13:0] MEM_LIM = 14'(MEM_WORDS);

  logic [31:0] mem_q [MEM_WORDS];

  req_t            in_q;
  logic [31:0]     acc_q, acc_d;
  logic [13:0]     pc_q, pc_d;
  logic            halt_q, halt_d;
  logic            fault_q, fault_d;
  logic [31:0]     rdata_q;
  logic            opnd_ok_q;
  logic [OP_W-1:0] op_q;
  logic [13:0]     addr_q;
  res_t            res_q, res_d;
  logic            done_q;
  logic [31:0]     cq_q, cq_d;

  logic [31:0] opnd, prod, div_q_fix, rd_mod;
  logic [31:0] dd, dv, quot;
  logic [31:0] cx, cm;
  logic [63:0] cprod;
  logic [31:0] rd_abs, rd_rem, dec_rem;
  logic        div_busy;
  logic        rd_en;
  logic [13:0] rd_addr;
  logic        we;
  logic [13:0] wa;
  logic [31:0] wd;
  logic        load_in_rng;
  logic        dvalid;
  logic [31:0] dvalue;

  assign opnd        = opnd_ok_q ? rdata_q : '0;
  assign prod        = acc_q * opnd;
  assign load_in_rng = in_q.load_address < MEM_LIM;
  assign rd_abs      = in_q.read_value[31] ? (32'd0 - in_q.read_value) : in_q.read_value;

  // Reciprocal split: quotient by DEC_SPLIT or READ_MOD, registered
  always_comb begin
    case (cmd_i.div_sel)
      DIV_READ: begin
        cx = rd_abs;
        cm = READ_MAGIC;
      end
      default: begin
        cx = rdata_q;
        cm = DEC_MAGIC;
      end
    endcase
  end

  assign cprod = 64'(cx) * 64'(cm);
  assign cq_d  = (cmd_i.div_sel == DIV_READ) ? 32'(cprod >> READ_SHIFT)
                                             : 32'(cprod >> DEC_SHIFT);

  // Remainders from the registered quotient
  assign dec_rem = rdata_q - cq_q * DEC_SPLIT;
  assign rd_rem  = rd_abs - cq_q * READ_MOD;

  // Accumulator divide on magnitudes
  assign dd = acc_q[31] ? (32'd0 - acc_q) : acc_q;
  assign dv = opnd[31] ? (32'd0 - opnd) : opnd;

  dac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start && (cmd_i.div_sel == DIV_ACC)),
    .dividend_i (dd),
    .divisor_i  (dv),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Sign fixups for truncating division
  assign div_q_fix = (acc_q[31] ^ opnd[31]) ? (32'd0 - quot) : quot;
  assign rd_mod    = in_q.read_value[31] ? (32'd0 - rd_rem) : rd_rem;

  // Instruction execute and next state
  always_comb begin
    acc_d   = acc_q;
    pc_d    = pc_q;
    halt_d  = halt_q;
    fault_d = fault_q;
    dvalid  = 1'b0;
    dvalue  = '0;
    we      = 1'b0;
    wa      = addr_q;
    wd      = acc_q;
    if (cmd_i.load_wr) begin
      we = load_in_rng;
      wa = in_q.load_address;
      wd = in_q.load_value;
    end else if (cmd_i.set_halt) begin
      halt_d = 1'b1;
    end else if (cmd_i.exec) begin
      pc_d = pc_q + 14'd1;
      case (op_q)
        OP_ADD:  acc_d = acc_q + opnd;
        OP_SUB:  acc_d = acc_q - opnd;
        OP_MUL:  acc_d = prod;
        OP_DIV: begin
          if (opnd == '0) begin
            halt_d  = 1'b1;
            fault_d = 1'b1;
            pc_d    = pc_q;
          end else begin
            acc_d = div_q_fix;
          end
        end
        OP_LDA:  acc_d = opnd;
        OP_STA:  we = opnd_ok_q;
        OP_READ: begin
          we = opnd_ok_q;
          wd = rd_mod;
        end
        OP_DISP: begin
          dvalid = 1'b1;
          dvalue = opnd;
        end
        OP_JMP:  pc_d = addr_q;
        OP_JNEG: if (acc_q[31]) pc_d = addr_q;
        OP_JZ:   if (acc_q == '0) pc_d = addr_q;
        OP_JPOS: if (!acc_q[31] && acc_q != '0) pc_d = addr_q;
        OP_HALT: begin
          halt_d = 1'b1;
          pc_d   = pc_q;
        end
        default: ;
      endcase
    end
  end

  // Result item
  always_comb begin
    res_d.load_ok       = cmd_i.load_wr & load_in_rng;
    res_d.display_valid = dvalid;
    res_d.display_value = dvalue;
    res_d.halted        = halt_d;
    res_d.divide_fault  = fault_d;
    res_d.next_pc       = pc_d;
  end

  // Memory: one write, one registered read
  assign rd_en   = cmd_i.rd_pc | cmd_i.rd_opnd;
  assign rd_addr = cmd_i.rd_pc ? pc_q : addr_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa[AW-1:0]] <= wd;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr[AW-1:0]];
    end
  end

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      pc_q    <= '0;
      halt_q  <= 1'b0;
      fault_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      fault_q <= fault_d;
      done_q  <= cmd_i.load_wr | cmd_i.fin_state | cmd_i.exec;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      in_q <= req_i;
    end
    if (cmd_i.div_start && (cmd_i.div_sel != DIV_ACC)) begin
      cq_q <= cq_d;
    end
    if (cmd_i.rd_opnd) begin
      opnd_ok_q <= addr_q < MEM_LIM;
    end
    if (cmd_i.cap_dec) begin
      op_q   <= cq_q[OP_W-1:0];
      addr_q <= dec_rem[13:0];
    end else if (cmd_i.clr_op) begin
      op_q   <= '0;
      addr_q <= '0;
    end
    if (cmd_i.load_wr | cmd_i.fin_state | cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign stat_o.req_type  = in_q.req_type;
  assign stat_o.halted    = halt_q;
  assign stat_o.pc_oob    = pc_q >= MEM_LIM;
  assign stat_o.word_nop  = rdata_q[31] | (rdata_q == '0);
  assign stat_o.div_busy  = div_busy;
  assign stat_o.need_div  = (op_q == OP_DIV) && (opnd != '0);
  assign stat_o.need_read = (op_q == OP_READ) && opnd_ok_q;

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> hdl/dac_ctrl.sv
// Controller state machine sequencing loads and the fetch, decode, operand read and execute of a step.
// Depends on dac_pkg.
module dac_ctrl
  import dac_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DISP = 7'b0000010,
    S_DEC  = 7'b0000100,
    S_DIVW = 7'b0001000,
    S_OPRD = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_DIVX = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_WORD;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      // dispatch on request kind and machine state
      S_DISP: begin
        if (stat_i.req_type == REQ_LOAD) begin
          cmd_o.load_wr = 1'b1;
          state_d       = S_IDLE;
        end else if (stat_i.halted) begin
          cmd_o.fin_state = 1'b1;
          state_d         = S_IDLE;
        end else if (stat_i.pc_oob) begin
          cmd_o.set_halt  = 1'b1;
          cmd_o.fin_state = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.rd_pc = 1'b1;
          state_d     = S_DEC;
        end
      end
      // split word into opcode and address
      S_DEC: begin
        if (stat_i.word_nop) begin
          cmd_o.clr_op = 1'b1;
          state_d      = S_OPRD;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_WORD;
          state_d         = S_DIVW;
        end
      end
      S_DIVW: begin
        if (!stat_i.div_busy) begin
          cmd_o.cap_dec = 1'b1;
          state_d       = S_OPRD;
        end
      end
      S_OPRD: begin
        cmd_o.rd_opnd = 1'b1;
        state_d       = S_CHK;
      end
      S_CHK: begin
        if (stat_i.need_div) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_ACC;
          state_d         = S_DIVX;
        end else if (stat_i.need_read) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_READ;
          state_d         = S_DIVX;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DIVX: begin
        if (!stat_i.div_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> hdl/dac_checker.sv
// Port-level checker for the accumulator machine, bound to the top level.
// Depends on dac_pkg.
module dac_checker
  import dac_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input res_t res_o
);

  logic seen_halt_q;

  // remember that a halt has been reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (done_o && res_o.halted) begin
      seen_halt_q <= 1'b1;
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without work");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && seen_halt_q |-> res_o.halted) else $error("halt flag cleared");

  a_fault_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.divide_fault |-> res_o.halted) else $error("fault without halt");

  a_disp_not_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.display_valid |-> !res_o.load_ok) else $error("display on load");

endmodule

bind decimal_accumulator_cpu_step_top dac_checker u_dac_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
